// ----- hw/rtl/fys_pkg.sv -----
`timescale 1ns / 1ps

package fys_pkg;

  localparam int DEPTH      = 64;
  localparam int ITEM_WIDTH = 32;
  localparam int VALUE_W    = 32;
  localparam int SEED_W     = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int RNG_W      = 48;
  localparam int HALF_W     = RNG_W / 2;
  localparam int MULT_W     = 35;

  localparam logic [MULT_W-1:0] LCG_MULT = 35'h5_DEEC_E66D;
  localparam logic [RNG_W-1:0]  LCG_ADD  = 48'h0000_0000_000B;
  localparam logic [15:0]       SEED_LOW = 16'h330E;

  // controller -> datapath
  typedef struct packed {
    logic store;       // write incoming item at fill slot
    logic i_load;      // i <= fill count, k <= 0
    logic lcg_a;       // low partial product of generator step
    logic lcg_b;       // finish generator step
    logic scale;       // j <= (x * i) >> 48
    logic swap_rd;     // read entries j and i-1
    logic wr_j;        // entry j <= old entry i-1
    logic wr_hi;       // entry i-1 <= old entry j, i decrements
    logic emit_rd;     // load output register with entry k
    logic list_clear;  // list done: clear fill count and overflow
  } fys_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_lt2;     // list shorter than two
    logic i_le2;       // this swap is the final one
    logic emit_last;   // entry k is the final one of the list
  } fys_sts_t;

endpackage

// ----- hw/rtl/fys_in_if.sv -----
`timescale 1ns / 1ps

interface fys_in_if import fys_pkg::*;;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] in_value;
  logic               in_last;

  modport source (output valid, output in_value, output in_last, input ready);
  modport sink   (input valid, input in_value, input in_last, output ready);
endinterface

// ----- hw/rtl/fys_out_if.sv -----
`timescale 1ns / 1ps

interface fys_out_if import fys_pkg::*;;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] out_value;
  logic               out_last;
  logic               out_overflow;

  modport source (output valid, output out_value, output out_last, output out_overflow,
                  input ready);
  modport sink   (input valid, input out_value, input out_last, input out_overflow,
                  output ready);
endinterface

// ----- hw/rtl/fys_datapath.sv -----
`timescale 1ns / 1ps

module fys_datapath import fys_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  fys_cmd_t           cmd,
  output fys_sts_t           sts,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               seed_we,
  input  logic [SEED_W-1:0]  seed_value,
  output logic [VALUE_W-1:0] out_value,
  output logic               out_last,
  output logic               out_overflow
);

  logic [ITEM_WIDTH-1:0] mem [DEPTH];

  logic [CNT_W-1:0]      fill_count;
  logic                  overflow_seen;
  logic [RNG_W-1:0]      rng;
  logic [RNG_W-1:0]      prod_lo;
  logic [CNT_W-1:0]      i_cnt;
  logic [CNT_W-1:0]      k_cnt;
  logic [IDX_W-1:0]      j_idx;
  logic [ITEM_WIDTH-1:0] rd_a;
  logic [ITEM_WIDTH-1:0] rd_b;
  logic [ITEM_WIDTH-1:0] out_item;

  logic [HALF_W+MULT_W-1:0] mul_lo_full;
  logic [2*HALF_W-1:0]      mul_hi_full;
  logic [RNG_W+CNT_W-1:0]   scale_full;
  logic [RNG_W-1:0]         rng_step;
  logic [IDX_W-1:0]         hi_idx;
  logic [IDX_W-1:0]         rd_addr;
  logic [IDX_W-1:0]         wr_addr;
  logic [ITEM_WIDTH-1:0]    wr_data;
  logic                     mem_we;
  logic                     full;

  // x*M mod 2^48 split as lo24*M + ((hi24*M[23:0]) mod 2^24) << 24
  assign mul_lo_full = rng[HALF_W-1:0] * LCG_MULT;
  assign mul_hi_full = rng[RNG_W-1:HALF_W] * LCG_MULT[HALF_W-1:0];
  assign rng_step    = prod_lo + {mul_hi_full[HALF_W-1:0], {HALF_W{1'b0}}} + LCG_ADD;
  assign scale_full  = rng * i_cnt;

  assign hi_idx  = IDX_W'(i_cnt - CNT_W'(1));
  assign full    = (fill_count == CNT_W'(DEPTH));
  assign rd_addr = cmd.emit_rd ? k_cnt[IDX_W-1:0] : j_idx;

  assign sts.cnt_lt2   = (fill_count < CNT_W'(2));
  assign sts.i_le2     = (i_cnt <= CNT_W'(2));
  assign sts.emit_last = ((k_cnt + CNT_W'(1)) == fill_count);

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = fill_count[IDX_W-1:0];
    wr_data = in_value[ITEM_WIDTH-1:0];
    if (cmd.store && !full) begin
      mem_we = 1'b1;
    end else if (cmd.wr_j) begin
      mem_we  = 1'b1;
      wr_addr = j_idx;
      wr_data = rd_b;
    end else if (cmd.wr_hi) begin
      mem_we  = 1'b1;
      wr_addr = hi_idx;
      wr_data = rd_a;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.swap_rd) begin
      rd_a <= mem[rd_addr];
      rd_b <= mem[hi_idx];
    end
    if (cmd.emit_rd) begin
      out_item <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      overflow_seen <= 1'b0;
      rng           <= {{(RNG_W-SEED_W-16){1'b0}}, {SEED_W{1'b0}}, SEED_LOW};
    end else begin
      if (cmd.store) begin
        if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          fill_count <= fill_count + CNT_W'(1);
        end
      end
      if (cmd.list_clear) begin
        fill_count    <= '0;
        overflow_seen <= 1'b0;
      end
      if (cmd.lcg_b) begin
        rng <= rng_step;
      end
      if (seed_we) begin
        rng <= {{(RNG_W-SEED_W-16){1'b0}}, seed_value, SEED_LOW};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lcg_a) begin
      prod_lo <= mul_lo_full[RNG_W-1:0];
    end
    if (cmd.scale) begin
      j_idx <= scale_full[RNG_W +: IDX_W];
    end
    if (cmd.i_load) begin
      i_cnt <= fill_count;
      k_cnt <= '0;
    end
    if (cmd.wr_hi) begin
      i_cnt <= i_cnt - CNT_W'(1);
    end
    if (cmd.emit_rd) begin
      k_cnt        <= k_cnt + CNT_W'(1);
      out_last     <= sts.emit_last;
      out_overflow <= overflow_seen;
    end
  end

  assign out_value = VALUE_W'(out_item);

endmodule

// ----- hw/rtl/fys_ctrl.sv -----
`timescale 1ns / 1ps

module fys_ctrl import fys_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  output fys_cmd_t cmd,
  input  fys_sts_t sts
);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_LCG_A,
    ST_LCG_B,
    ST_SCALE,
    ST_READ,
    ST_WR_J,
    ST_WR_HI,
    ST_EMIT
  } state_t;

  state_t state;
  logic   accept;
  logic   out_free;

  assign in_ready = (state == ST_LOAD);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_LOAD:  cmd.store   = accept;
      ST_START: cmd.i_load  = 1'b1;
      ST_LCG_A: cmd.lcg_a   = 1'b1;
      ST_LCG_B: cmd.lcg_b   = 1'b1;
      ST_SCALE: cmd.scale   = 1'b1;
      ST_READ:  cmd.swap_rd = 1'b1;
      ST_WR_J:  cmd.wr_j    = 1'b1;
      ST_WR_HI: cmd.wr_hi   = 1'b1;
      ST_EMIT: begin
        cmd.emit_rd    = out_free;
        cmd.list_clear = out_free && sts.emit_last;
      end
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit_rd) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (accept && in_last) state <= ST_START;
        end
        // hold off until the previous list's final item has left the output register
        ST_START: begin
          if (!out_valid) state <= sts.cnt_lt2 ? ST_EMIT : ST_LCG_A;
        end
        ST_LCG_A: state <= ST_LCG_B;
        ST_LCG_B: state <= ST_SCALE;
        ST_SCALE: state <= ST_READ;
        ST_READ:  state <= ST_WR_J;
        ST_WR_J:  state <= ST_WR_HI;
        ST_WR_HI: state <= sts.i_le2 ? ST_EMIT : ST_LCG_A;
        ST_EMIT: begin
          if (out_free && sts.emit_last) state <= ST_LOAD;
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

// ----- hw/rtl/fisher_yates_shuffle_rand48.sv -----
`timescale 1ns / 1ps
// Load: one item per cycle; in_last ends the list and starts the shuffle.
// Shuffle: n-1 swaps, each a two-step 48-bit LCG multiply, a scale multiply,
// a dual read and two writes on the single store write port.
// Results then leave one item per cycle while the output is not stalled.
// Reset (sync, active high): empty list, no overflow, generator = 0x330E, store contents undefined.

module fisher_yates_shuffle_rand48 import fys_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  fys_in_if.sink            item_in,
  fys_out_if.source         item_out,
  input  logic              seed_we,
  input  logic [SEED_W-1:0] seed_value
);

  // Controller sequences load / swap / emit; datapath owns the item store,
  // the rand48 generator, the counters and the output register.
  fys_cmd_t cmd;
  fys_sts_t sts;

  fys_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_in.valid),
    .in_last   (item_in.in_last),
    .in_ready  (item_in.ready),
    .out_ready (item_out.ready),
    .out_valid (item_out.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Generator state persists across lists; a seed write reloads it.
  // Items beyond DEPTH are dropped and the list is flagged as overflowed.
  fys_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_value     (item_in.in_value),
    .seed_we      (seed_we),
    .seed_value   (seed_value),
    .out_value    (item_out.out_value),
    .out_last     (item_out.out_last),
    .out_overflow (item_out.out_overflow)
  );

endmodule

// ----- hw/rtl/fys_checker.sv -----
`timescale 1ns / 1ps

module fys_checker import fys_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_last,
  input logic               out_valid,
  input logic               out_ready,
  input logic [VALUE_W-1:0] out_value,
  input logic               out_last,
  input logic               out_overflow
);

  // a stalled item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output item withdrawn while stalled");

  // a stalled item keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_last) && $stable(out_overflow))
    else $error("output payload changed while stalled");

  // end of list: input closes while the shuffle runs
  a_close_on_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input still open after last item");

  // no result directly after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind fisher_yates_shuffle_rand48 fys_checker u_fys_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (item_in.valid),
  .in_ready     (item_in.ready),
  .in_last      (item_in.in_last),
  .out_valid    (item_out.valid),
  .out_ready    (item_out.ready),
  .out_value    (item_out.out_value),
  .out_last     (item_out.out_last),
  .out_overflow (item_out.out_overflow)
);
